// ----- sv/bosg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bosg_pkg
// Shared types and constants of the block offset sequence generator.
// ----------------------------------------------------------------------------
package bosg_pkg;

    localparam int DW = 64;

    // register indexes of the configuration port
    localparam logic [2:0] REG_BLOCK  = 3'd0;
    localparam logic [2:0] REG_DSET   = 3'd1;
    localparam logic [2:0] REG_MODE   = 3'd2;
    localparam logic [2:0] REG_SEED   = 3'd3;
    localparam logic [2:0] REG_DEPTH  = 3'd4;
    localparam logic [2:0] REG_WINDOW = 3'd5;
    localparam logic [2:0] REG_TOTAL  = 3'd6;

    // access modes
    localparam logic [1:0] MODE_SEQ = 2'd0;
    localparam logic [1:0] MODE_WIN = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // hash constants
    localparam logic [63:0] MIX_ADD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_M1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_M2  = 64'h94D049BB133111EB;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIV,
        OP_MUL,
        OP_INIT,
        OP_LD_DSET_BLK,
        OP_SET_BC,
        OP_LD_SPAN,
        OP_SET_SPAN,
        OP_LD_WIN,
        OP_SET_WIN,
        OP_MIX_SEED,
        OP_MIX_BLK,
        OP_MIX_DEP,
        OP_MIX1,
        OP_MIX2,
        OP_LD_Y_T,
        OP_LD_R_DOM,
        OP_SET_WB,
        OP_LD_Y_DOM,
        OP_SET_START,
        OP_OR1_DOM,
        OP_SET_STRIDE,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_BUMP,
        OP_STATUS,
        OP_LD_IDX_BC,
        OP_LD_R_BLK,
        OP_LD_IDX_DOM,
        OP_LD_R_STR,
        OP_SUM
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic unit_done;
        logic bad;
        logic mode_seq;
        logic mode_win;
        logic y_zero;
        logic x_one;
        logic stat_nz;
        logic cfg_hit;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/block_offset_sequence_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_offset_sequence_generator_core
// Maps a request index to the byte offset of the storage block it reads.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index
//   and i_cfg_data. Write only while busy is low. Any write to a known
//   register forces the derived values to be recomputed on the next request.
//   Request: pulse start with i_request_index while busy is low. One
//   transaction is in flight at a time.
//   Result: o_strobe is high for one cycle with o_byte_offset, o_status and
//   o_last; the receiver cannot stall, so a result is never held back.
// Arithmetic: requests run on the shared radix-2 divider and the wrapping
//   multiplier; a request with nonzero status skips them. The first request
//   after reset or a register write also runs the derivation; pseudorandom
//   and windowed modes end it with the coprime stride search, which repeats
//   remainder steps and stride bumps.
// Reset: synchronous, active low; registers return to their defaults and the
//   derived values are marked stale.
// ----------------------------------------------------------------------------
module block_offset_sequence_generator_core
    import bosg_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int INDEX_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [DW-1:0]         i_cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [INDEX_BITS-1:0] i_request_index,
    output logic                       o_strobe,
    output logic [OFFSET_BITS-1:0]     o_byte_offset,
    output logic [1:0]                 o_status,
    output logic                       o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    bosg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    bosg_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_request_index (i_request_index),
        .o_byte_offset   (o_byte_offset),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

// ----- sv/bosg_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bosg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bosg_div
    import bosg_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [DW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // shift in next numerator bit, trial subtract
    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- sv/bosg_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bosg_mul
// Wrapping 64x64 multiplier, 16 multiplier bits per cycle.
// ----------------------------------------------------------------------------
module bosg_mul
    import bosg_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_a,
    input  wire logic [DW-1:0] i_b,
    output logic               o_done,
    output logic [DW-1:0]      o_prod
);

    localparam int SW    = 16;
    localparam int STEPS = DW / SW;
    localparam int CW    = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_a;
    logic [DW-1:0]    r_b;
    logic [DW-1:0]    r_acc;
    logic [DW+SW-1:0] w_pp;

    // one partial product per cycle
    assign w_pp = {{SW{1'b0}}, r_a} * {{DW{1'b0}}, r_b[SW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp[DW-1:0];
            r_a   <= r_a << SW;
            r_b   <= r_b >> SW;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// ----- sv/bosg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bosg_dp
// Datapath: configuration registers, derived values, operand registers,
// shared divider and multiplier, result registers.
// ----------------------------------------------------------------------------
module bosg_dp
    import bosg_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int INDEX_BITS  = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic                   i_cfg_valid,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [DW-1:0]          i_cfg_data,
    input  wire logic [INDEX_BITS-1:0]  i_request_index,
    output logic [OFFSET_BITS-1:0]      o_byte_offset,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    // configuration
    logic [31:0]            r_block;
    logic [OFFSET_BITS-1:0] r_dataset;
    logic [1:0]             r_mode;
    logic [DW-1:0]          r_seed;
    logic [31:0]            r_depth;
    logic [OFFSET_BITS-1:0] r_window;
    logic [31:0]            r_total;
    logic                   w_cfg_hit;

    // derived values and working registers
    logic [INDEX_BITS-1:0]  r_idx;
    logic [DW-1:0]          r_bc, r_dom, r_wb, r_start, r_stride;
    logic [DW-1:0]          r_x, r_y, r_t;
    logic [1:0]             r_stat;
    logic                   r_last;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [1:0]             r_ostat;
    logic                   r_olast;

    logic [DW-1:0] w_block, w_dataset, w_window, w_total, w_idx;
    logic [DW-1:0] w_quo, w_rem, w_prod, w_v, w_span, w_bump;
    logic          w_div_done, w_mul_done;

    assign w_block   = DW'(r_block);
    assign w_dataset = DW'(r_dataset);
    assign w_window  = DW'(r_window);
    assign w_total   = DW'(r_total);
    assign w_idx     = DW'(r_idx);

    // configuration writes
    always_comb begin
        unique case (i_cfg_index)
            REG_BLOCK, REG_DSET, REG_MODE, REG_SEED,
            REG_DEPTH, REG_WINDOW, REG_TOTAL: w_cfg_hit = i_cfg_valid;
            default:                          w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block   <= 32'd65536;
            r_dataset <= '0;
            r_mode    <= MODE_SEQ;
            r_seed    <= '0;
            r_depth   <= 32'd1;
            r_window  <= '0;
            r_total   <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BLOCK:  r_block   <= i_cfg_data[31:0];
                REG_DSET:   r_dataset <= i_cfg_data[OFFSET_BITS-1:0];
                REG_MODE:   r_mode    <= i_cfg_data[1:0];
                REG_SEED:   r_seed    <= i_cfg_data;
                REG_DEPTH:  r_depth   <= i_cfg_data[31:0];
                REG_WINDOW: r_window  <= i_cfg_data[OFFSET_BITS-1:0];
                REG_TOTAL:  r_total   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // shared arithmetic units
    bosg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (r_x),
        .i_den   (r_y),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    bosg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_MUL),
        .i_a     (r_x),
        .i_b     (r_y),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // hash input and small helpers
    always_comb begin
        case (i_cmd.op)
            OP_MIX_BLK: w_v = (r_seed ^ w_block) + MIX_ADD;
            OP_MIX_DEP: w_v = (r_seed ^ DW'(r_depth)) + MIX_ADD;
            default:    w_v = r_seed + MIX_ADD;
        endcase
    end

    always_comb begin
        w_span = (w_quo > r_bc) ? r_bc : w_quo;
        if (w_span == '0) w_span = DW'(1);
    end

    assign w_bump = r_stride + DW'(2);

    // operation execute
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: r_idx <= i_request_index;
            OP_INIT: begin
                r_bc     <= '0;
                r_dom    <= '0;
                r_wb     <= '0;
                r_start  <= '0;
                r_stride <= DW'(1);
            end
            OP_LD_DSET_BLK: begin
                r_x <= w_dataset;
                r_y <= w_block;
            end
            OP_SET_BC: begin
                r_bc  <= w_quo;
                r_dom <= w_quo;
            end
            OP_LD_SPAN: begin
                r_x <= (w_window > w_block) ? w_window : w_block;
                r_y <= w_block;
            end
            OP_SET_SPAN: r_dom <= w_span;
            OP_LD_WIN: begin
                r_x <= r_bc;
                r_y <= r_dom;
            end
            OP_SET_WIN: r_t <= (w_quo == '0) ? DW'(1) : w_quo;
            OP_MIX_SEED, OP_MIX_BLK, OP_MIX_DEP: begin
                r_x <= w_v ^ (w_v >> 30);
                r_y <= MIX_M1;
            end
            OP_MIX1: begin
                r_x <= w_prod ^ (w_prod >> 27);
                r_y <= MIX_M2;
            end
            OP_MIX2:     r_x <= w_prod ^ (w_prod >> 31);
            OP_LD_Y_T:   r_y <= r_t;
            OP_LD_R_DOM: begin
                r_x <= w_rem;
                r_y <= r_dom;
            end
            OP_SET_WB:    r_wb <= w_prod;
            OP_LD_Y_DOM:  r_y <= r_dom;
            OP_SET_START: r_start <= w_rem;
            OP_OR1_DOM: begin
                r_x <= r_x | DW'(1);
                r_y <= r_dom;
            end
            OP_SET_STRIDE: r_stride <= (w_rem == '0) ? DW'(1) : w_rem;
            OP_GCD_INIT: begin
                r_x <= r_stride;
                r_y <= r_dom;
            end
            OP_GCD_STEP: begin
                r_x <= r_y;
                r_y <= w_rem;
            end
            OP_BUMP: r_stride <= (w_bump >= r_dom) ? DW'(1) : w_bump;
            OP_STATUS: begin
                if (r_bc == '0) begin
                    r_stat <= ST_EMPTY;
                    r_last <= 1'b0;
                end else if (w_idx >= w_total) begin
                    r_stat <= ST_RANGE;
                    r_last <= 1'b0;
                end else begin
                    r_stat <= ST_OK;
                    r_last <= (w_idx == w_total - DW'(1));
                end
            end
            OP_LD_IDX_BC: begin
                r_x <= w_idx;
                r_y <= r_bc;
            end
            // window base is zero outside windowed mode
            OP_LD_R_BLK: begin
                r_x <= r_wb + w_rem;
                r_y <= w_block;
            end
            OP_LD_IDX_DOM: begin
                r_x <= w_idx;
                r_y <= r_dom;
            end
            OP_LD_R_STR: begin
                r_x <= w_rem;
                r_y <= r_stride;
                r_t <= w_quo;
            end
            OP_SUM: begin
                r_x <= r_start + w_prod + r_t;
                r_y <= r_dom;
            end
            default: ;
        endcase
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_offset <= (r_stat == ST_OK) ? w_prod[OFFSET_BITS-1:0] : '0;
            r_ostat  <= r_stat;
            r_olast  <= r_last;
        end
    end

    // status to controller
    always_comb begin
        o_stat.unit_done = w_div_done | w_mul_done;
        o_stat.bad       = (r_block == '0) || (w_dataset < w_block);
        o_stat.mode_seq  = (r_mode == MODE_SEQ);
        o_stat.mode_win  = (r_mode == MODE_WIN);
        o_stat.y_zero    = (r_y == '0);
        o_stat.x_one     = (r_x == DW'(1));
        o_stat.stat_nz   = (r_stat != ST_OK);
        o_stat.cfg_hit   = w_cfg_hit;
    end

    assign o_byte_offset = r_offset;
    assign o_status      = r_ostat;
    assign o_last        = r_olast;

endmodule
`default_nettype wire

// ----- sv/bosg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bosg_ctrl
// Controller: sequences derivation and per-request address computation
// as operations on the datapath.
// ----------------------------------------------------------------------------
module bosg_ctrl
    import bosg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    output logic       o_busy,
    output logic       o_strobe,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    typedef enum logic [31:0] {
        S_IDLE   = 32'h0000_0001,
        S_D_INIT = 32'h0000_0002,
        S_D_BC0  = 32'h0000_0004,
        S_D_BC1  = 32'h0000_0008,
        S_D_SP0  = 32'h0000_0010,
        S_D_SP1  = 32'h0000_0020,
        S_D_WN0  = 32'h0000_0040,
        S_D_WN1  = 32'h0000_0080,
        S_D_WB0  = 32'h0000_0100,
        S_D_WB1  = 32'h0000_0200,
        S_D_WB2  = 32'h0000_0400,
        S_D_ST0  = 32'h0000_0800,
        S_D_ST1  = 32'h0000_1000,
        S_D_ST2  = 32'h0000_2000,
        S_D_SR1  = 32'h0000_4000,
        S_D_SR2  = 32'h0000_8000,
        S_D_G0   = 32'h0001_0000,
        S_D_G1   = 32'h0002_0000,
        S_D_G2   = 32'h0004_0000,
        S_M0     = 32'h0008_0000,
        S_M1     = 32'h0010_0000,
        S_M2     = 32'h0020_0000,
        S_GO_DIV = 32'h0040_0000,
        S_GO_MUL = 32'h0080_0000,
        S_WAIT   = 32'h0100_0000,
        S_X_STAT = 32'h0200_0000,
        S_X_CHK  = 32'h0400_0000,
        S_X_Q1   = 32'h0800_0000,
        S_X_R1   = 32'h1000_0000,
        S_X_R2   = 32'h2000_0000,
        S_X_R3   = 32'h4000_0000,
        S_X_OUT  = 32'h8000_0000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_state r_mret, n_mret;
    t_op    r_msel, n_msel;
    logic   r_derived, n_derived;
    logic   r_strobe;

    // next state and command
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_mret       = r_mret;
        n_msel       = r_msel;
        n_derived    = r_derived;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        if (i_stat.cfg_hit) n_derived = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = r_derived ? S_X_STAT : S_D_INIT;
                end
            end
            S_D_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = i_stat.bad ? S_X_STAT : S_D_BC0;
            end
            S_D_BC0: begin
                o_cmd.op = OP_LD_DSET_BLK;
                n_ret    = S_D_BC1;
                n_state  = S_GO_DIV;
            end
            S_D_BC1: begin
                o_cmd.op = OP_SET_BC;
                if (i_stat.mode_win)      n_state = S_D_SP0;
                else if (i_stat.mode_seq) n_state = S_X_STAT;
                else                      n_state = S_D_ST0;
            end
            S_D_SP0: begin
                o_cmd.op = OP_LD_SPAN;
                n_ret    = S_D_SP1;
                n_state  = S_GO_DIV;
            end
            S_D_SP1: begin
                o_cmd.op = OP_SET_SPAN;
                n_state  = S_D_WN0;
            end
            S_D_WN0: begin
                o_cmd.op = OP_LD_WIN;
                n_ret    = S_D_WN1;
                n_state  = S_GO_DIV;
            end
            S_D_WN1: begin
                o_cmd.op = OP_SET_WIN;
                n_msel   = OP_MIX_SEED;
                n_mret   = S_D_WB0;
                n_state  = S_M0;
            end
            S_D_WB0: begin
                o_cmd.op = OP_LD_Y_T;
                n_ret    = S_D_WB1;
                n_state  = S_GO_DIV;
            end
            S_D_WB1: begin
                o_cmd.op = OP_LD_R_DOM;
                n_ret    = S_D_WB2;
                n_state  = S_GO_MUL;
            end
            S_D_WB2: begin
                o_cmd.op = OP_SET_WB;
                n_state  = S_D_ST0;
            end
            S_D_ST0: begin
                n_msel  = OP_MIX_BLK;
                n_mret  = S_D_ST1;
                n_state = S_M0;
            end
            S_D_ST1: begin
                o_cmd.op = OP_LD_Y_DOM;
                n_ret    = S_D_ST2;
                n_state  = S_GO_DIV;
            end
            S_D_ST2: begin
                o_cmd.op = OP_SET_START;
                n_msel   = OP_MIX_DEP;
                n_mret   = S_D_SR1;
                n_state  = S_M0;
            end
            S_D_SR1: begin
                o_cmd.op = OP_OR1_DOM;
                n_ret    = S_D_SR2;
                n_state  = S_GO_DIV;
            end
            S_D_SR2: begin
                o_cmd.op = OP_SET_STRIDE;
                n_state  = S_D_G0;
            end
            // coprime search: gcd by repeated remainder
            S_D_G0: begin
                o_cmd.op = OP_GCD_INIT;
                n_state  = S_D_G1;
            end
            S_D_G1: begin
                if (i_stat.y_zero) begin
                    if (i_stat.x_one) begin
                        n_state = S_X_STAT;
                    end else begin
                        o_cmd.op = OP_BUMP;
                        n_state  = S_D_G0;
                    end
                end else begin
                    n_ret   = S_D_G2;
                    n_state = S_GO_DIV;
                end
            end
            S_D_G2: begin
                o_cmd.op = OP_GCD_STEP;
                n_state  = S_D_G1;
            end
            // hash subroutine
            S_M0: begin
                o_cmd.op = r_msel;
                n_ret    = S_M1;
                n_state  = S_GO_MUL;
            end
            S_M1: begin
                o_cmd.op = OP_MIX1;
                n_ret    = S_M2;
                n_state  = S_GO_MUL;
            end
            S_M2: begin
                o_cmd.op = OP_MIX2;
                n_state  = r_mret;
            end
            // unit launch and wait
            S_GO_DIV: begin
                o_cmd.op = OP_DIV;
                n_state  = S_WAIT;
            end
            S_GO_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.unit_done) n_state = r_ret;
            end
            // per-request computation
            S_X_STAT: begin
                o_cmd.op  = OP_STATUS;
                n_derived = 1'b1;
                n_state   = S_X_CHK;
            end
            S_X_CHK: begin
                if (i_stat.stat_nz) begin
                    n_state = S_X_OUT;
                end else if (i_stat.mode_seq) begin
                    o_cmd.op = OP_LD_IDX_BC;
                    n_ret    = S_X_Q1;
                    n_state  = S_GO_DIV;
                end else begin
                    o_cmd.op = OP_LD_IDX_DOM;
                    n_ret    = S_X_R1;
                    n_state  = S_GO_DIV;
                end
            end
            S_X_Q1: begin
                o_cmd.op = OP_LD_R_BLK;
                n_ret    = S_X_OUT;
                n_state  = S_GO_MUL;
            end
            S_X_R1: begin
                o_cmd.op = OP_LD_R_STR;
                n_ret    = S_X_R2;
                n_state  = S_GO_MUL;
            end
            S_X_R2: begin
                o_cmd.op = OP_SUM;
                n_ret    = S_X_R3;
                n_state  = S_GO_DIV;
            end
            S_X_R3: begin
                o_cmd.op = OP_LD_R_BLK;
                n_ret    = S_X_OUT;
                n_state  = S_GO_MUL;
            end
            S_X_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_mret    <= S_IDLE;
            r_msel    <= OP_MIX_SEED;
            r_derived <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_mret    <= n_mret;
            r_msel    <= n_msel;
            r_derived <= n_derived;
            r_strobe  <= (r_state == S_X_OUT);
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire
